// ----- hw/rtl/izk_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, fixed-point constants and saturation helper for the
// Izhikevich RK2 neuron step. No dependencies.
package izk_pkg;

   // Q16.16 / Q0.16 coefficients
   localparam logic [11:0]        COEF_SQ     = 12'd2621;      // 0.04
   localparam logic signed [14:0] COEF_H      = 15'sd6554;     // 0.1 ms step
   localparam logic signed [35:0] CONST_140   = 36'sd9175040;  // 140.0
   localparam logic signed [31:0] SPIKE_LEVEL = 32'sd1966080;  // 30.0

   // synaptic ring limits
   localparam int unsigned TAU_MAX = 32;
   localparam int unsigned TAU_LIM = (TAU_MAX < 32) ? TAU_MAX : 32;
   localparam logic [5:0]  DUR_LIMIT = 6'(TAU_LIM);
   localparam logic [5:0]  DUR_RESET = 6'd10;

   // per-item fields that travel beside the arithmetic
   typedef struct packed {
      logic signed [31:0] pot;
      logic signed [31:0] rec;
      logic [15:0]        rate_a;
      logic [15:0]        sens_b;
      logic signed [31:0] reset_level;
      logic signed [31:0] recovery_jump;
      logic signed [31:0] drive;
      logic [4:0]         hold_timer;
      logic [31:0]        slot_mask;
      logic [4:0]         slot_now;
   } side_type;

   // clip a wide signed sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      logic in_range;
      in_range = (&x[47:31]) || !(|x[47:31]);
      if (in_range) begin
         return x[31:0];
      end else if (x[47]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

endpackage

// ----- hw/rtl/izk_eval.sv -----
`timescale 1ns / 1ps
// Three-stage pipelined evaluation of h*f(v,u) and h*g(v,u).
// Depends on izk_pkg for the coefficients.
module izk_eval (
   input  logic               clock,
   input  logic [2:0]         en,
   input  logic signed [31:0] pot,
   input  logic signed [31:0] rec,
   input  logic [15:0]        rate_a,
   input  logic [15:0]        sens_b,
   input  logic signed [31:0] drive,
   output logic signed [43:0] dv,
   output logic signed [33:0] du
);
   import izk_pkg::*;

   // stage 1: square, b*v, linear terms
   logic [31:0]        mag;
   logic [63:0]        sq_full;
   logic signed [48:0] bv_full;
   logic signed [35:0] lin_in;
   logic [46:0]        sq_ff;
   logic signed [32:0] bv_ff;
   logic signed [35:0] lin_ff;
   logic signed [31:0] rec_ff;
   logic [15:0]        rate_ff;

   // stage 2: 0.04*v^2 + linear, a*(b*v - u)
   logic [58:0]        quad_full;
   logic signed [44:0] f_in;
   logic signed [33:0] diff;
   logic signed [50:0] ag_full;
   logic signed [44:0] f_ff;
   logic signed [34:0] ag_ff;

   // stage 3: scale by h
   logic signed [59:0] dv_full;
   logic signed [49:0] du_full;
   logic signed [43:0] dv_ff;
   logic signed [33:0] du_ff;

   always_comb begin
      mag     = pot[31] ? (~pot + 32'd1) : pot;
      sq_full = mag * mag;
      bv_full = $signed({1'b0, sens_b}) * pot;
      lin_in  = ({{4{pot[31]}}, pot} <<< 2) + {{4{pot[31]}}, pot} + CONST_140
              - {{4{rec[31]}}, rec} + {{4{drive[31]}}, drive};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ff   <= sq_full[62:16];
         bv_ff   <= bv_full[48:16];
         lin_ff  <= lin_in;
         rec_ff  <= rec;
         rate_ff <= rate_a;
      end
   end

   always_comb begin
      quad_full = sq_ff * COEF_SQ;
      f_in      = $signed({2'b00, quad_full[58:16]}) + {{9{lin_ff[35]}}, lin_ff};
      diff      = {bv_ff[32], bv_ff} - {{2{rec_ff[31]}}, rec_ff};
      ag_full   = $signed({1'b0, rate_ff}) * diff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         f_ff  <= f_in;
         ag_ff <= ag_full[50:16];
      end
   end

   always_comb begin
      dv_full = f_ff * COEF_H;
      du_full = ag_ff * COEF_H;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         dv_ff <= dv_full[59:16];
         du_ff <= du_full[49:16];
      end
   end

   assign dv = dv_ff;
   assign du = du_ff;

endmodule

// ----- hw/rtl/izhikevich_neuron_rk2_step.sv -----
`timescale 1ns / 1ps
// Izhikevich neuron, one 0.1 ms midpoint Runge-Kutta step per transfer.
// Depends on izk_pkg and izk_eval.
//
// Usage: present one neuron's v, u, a, b, c, d, drive, hold timer, slot
// mask and current slot on the req_ channel; the updated neuron comes out
// on the rsp_ channel in the same order. A transfer happens on a rising
// edge with valid high and stall low on that channel.
// A neuron goes from input transfer to rsp_valid through two passes of the
// three-stage izk_eval unit, a midpoint stage, a sum stage and the output
// register. Throughput is one neuron per cycle while rsp_stall is low.
// Every stage loads when it is empty or when the stage after it moves, so
// bubbles close up and an input is taken while a result waits on the
// output as long as some stage is empty. A stalled output stops the whole
// pipe only once all nine stages are full; nothing is dropped.
// csr_wr_en writes the synapse duration (ring slots in use); write it only
// while the pipe is empty. Reset empties the pipe and loads a duration of
// 10.
module izhikevich_neuron_rk2_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [5:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_potential,
   input  logic signed [31:0] req_recovery,
   input  logic [15:0]        req_rate_a,
   input  logic [15:0]        req_sensitivity_b,
   input  logic signed [31:0] req_reset_level,
   input  logic signed [31:0] req_recovery_jump,
   input  logic signed [31:0] req_drive,
   input  logic [4:0]         req_hold_timer,
   input  logic [31:0]        req_slot_mask,
   input  logic [4:0]         req_slot_now,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_potential_next,
   output logic signed [31:0] rsp_recovery_next,
   output logic [4:0]         rsp_hold_timer_next,
   output logic [31:0]        rsp_slot_mask_next,
   output logic               rsp_spiked,
   output logic signed [31:0] rsp_trace_value
);
   import izk_pkg::*;

   localparam int NSTAGE = 9;

   logic [5:0]         duration_ff;
   logic [NSTAGE-1:0]  vld_ff;
   logic [NSTAGE-1:0]  ld;
   side_type           side_in;
   side_type           side_ff [0:NSTAGE-2];

   logic signed [43:0] dv1, dv2;
   logic signed [33:0] du1, du2;
   logic signed [43:0] half_dv;
   logic signed [33:0] half_du;
   logic signed [31:0] vm_ff, um_ff;
   logic signed [31:0] vn_ff, un_ff;

   // output stage
   logic [5:0]         tau;
   logic [32:0]        tau_bit;
   logic [31:0]        fill;
   logic [4:0]         next_slot;
   logic               spike;
   logic signed [31:0] pot_in, rec_in, trace_in;
   logic [4:0]         timer_in;
   logic [31:0]        mask_in;
   logic signed [31:0] pot_ff, rec_ff, trace_ff;
   logic [4:0]         timer_ff;
   logic [31:0]        mask_ff;
   logic               spiked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= DUR_RESET;
      end else if (csr_wr_en) begin
         duration_ff <= csr_wr_data;
      end
   end

   // a stage loads when empty or when its successor moves on
   always_comb begin
      ld[NSTAGE-1] = !vld_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   assign req_stall = !ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (ld[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      side_in.pot           = req_potential;
      side_in.rec           = req_recovery;
      side_in.rate_a        = req_rate_a;
      side_in.sens_b        = req_sensitivity_b;
      side_in.reset_level   = req_reset_level;
      side_in.recovery_jump = req_recovery_jump;
      side_in.drive         = req_drive;
      side_in.hold_timer    = req_hold_timer;
      side_in.slot_mask     = req_slot_mask;
      side_in.slot_now      = req_slot_now;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         side_ff[0] <= side_in;
      end
      for (int k = 1; k < NSTAGE - 1; k++) begin
         if (ld[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // first slope, stages 0..2
   izk_eval u_eval_a (
      .clock  (clock),
      .en     (ld[2:0]),
      .pot    (req_potential),
      .rec    (req_recovery),
      .rate_a (req_rate_a),
      .sens_b (req_sensitivity_b),
      .drive  (req_drive),
      .dv     (dv1),
      .du     (du1)
   );

   // midpoint, stage 3
   assign half_dv = dv1 >>> 1;
   assign half_du = du1 >>> 1;

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         vm_ff <= sat32({{16{side_ff[2].pot[31]}}, side_ff[2].pot}
                      + {{4{half_dv[43]}}, half_dv});
         um_ff <= sat32({{16{side_ff[2].rec[31]}}, side_ff[2].rec}
                      + {{14{half_du[33]}}, half_du});
      end
   end

   // slope at the midpoint, stages 4..6
   izk_eval u_eval_b (
      .clock  (clock),
      .en     (ld[6:4]),
      .pot    (vm_ff),
      .rec    (um_ff),
      .rate_a (side_ff[3].rate_a),
      .sens_b (side_ff[3].sens_b),
      .drive  (side_ff[3].drive),
      .dv     (dv2),
      .du     (du2)
   );

   // full step, stage 7
   always_ff @(posedge clock) begin
      if (ld[7]) begin
         vn_ff <= sat32({{16{side_ff[6].pot[31]}}, side_ff[6].pot}
                      + {{4{dv2[43]}}, dv2});
         un_ff <= sat32({{16{side_ff[6].rec[31]}}, side_ff[6].rec}
                      + {{14{du2[33]}}, du2});
      end
   end

   // spike, clamp and ring update, stage 8
   always_comb begin
      if (duration_ff == 6'd0) begin
         tau = 6'd1;
      end else if (duration_ff > DUR_LIMIT) begin
         tau = DUR_LIMIT;
      end else begin
         tau = duration_ff;
      end
      tau_bit   = 33'd1 << tau;
      fill      = 32'(tau_bit - 33'd1);
      next_slot = ({1'b0, side_ff[7].slot_now} >= (tau - 6'd1)) ? 5'd0
                : side_ff[7].slot_now + 5'd1;
      spike     = (vn_ff >= SPIKE_LEVEL);

      if (spike) begin
         if ({1'b0, side_ff[7].slot_now} < tau) begin
            fill[side_ff[7].slot_now] = 1'b0;
         end
         mask_in  = side_ff[7].slot_mask | fill;
         timer_in = 5'(tau - 6'd1);
         pot_in   = side_ff[7].reset_level;
         rec_in   = sat32({{16{un_ff[31]}}, un_ff}
                        + {{16{side_ff[7].recovery_jump[31]}}, side_ff[7].recovery_jump});
         trace_in = SPIKE_LEVEL;
      end else begin
         mask_in  = side_ff[7].slot_mask;
         timer_in = side_ff[7].hold_timer;
         pot_in   = (vn_ff < side_ff[7].reset_level) ? side_ff[7].reset_level : vn_ff;
         rec_in   = un_ff;
         trace_in = pot_in;
         if (side_ff[7].hold_timer == 5'd0) begin
            mask_in[next_slot] = 1'b0;
         end else begin
            timer_in = side_ff[7].hold_timer - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[8]) begin
         pot_ff    <= pot_in;
         rec_ff    <= rec_in;
         timer_ff  <= timer_in;
         mask_ff   <= mask_in;
         spiked_ff <= spike;
         trace_ff  <= trace_in;
      end
   end

   assign rsp_valid           = vld_ff[NSTAGE-1];
   assign rsp_potential_next  = pot_ff;
   assign rsp_recovery_next   = rec_ff;
   assign rsp_hold_timer_next = timer_ff;
   assign rsp_slot_mask_next  = mask_ff;
   assign rsp_spiked          = spiked_ff;
   assign rsp_trace_value     = trace_ff;

   // an empty entry stage never pushes back
   a_entry_open: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> !req_stall)
      else $error("input stalled with empty entry stage");

   // without a spike the trace is the clamped potential
   a_trace_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_spiked |-> rsp_trace_value == rsp_potential_next)
      else $error("trace differs from potential on a quiet step");

   // a spike reloads the timer from the ring length
   a_spike_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spiked |-> rsp_hold_timer_next == 5'(tau - 6'd1))
      else $error("timer not reloaded on spike");

endmodule
